[sv/ledbf_pkg.sv]
// Shared types, codes and the gear brightness table for the LED indicator core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ledbf_pkg;

	localparam int unsigned CntW    = 16;
	localparam int unsigned DutyW   = 8;
	localparam int unsigned GearW   = 3;
	localparam int unsigned GearInW = 8;
	localparam int unsigned ModeInW = 3;
	localparam int unsigned KindW   = 2;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 16;

	localparam logic [GearW-1:0]   GearMax   = 3'd4;
	localparam logic [CntW-1:0]    CntMax    = 16'hFFFF;
	localparam logic [DutyW-1:0]   DutyFull  = 8'd255;

	localparam logic [CntW-1:0] FlashDurRst = 16'd100;
	localparam logic [CntW-1:0] SlowIvlRst  = 16'd500;
	localparam logic [CntW-1:0] FastIvlRst  = 16'd100;

	// request kinds
	localparam logic [KindW-1:0] KIND_TICK = 2'd0;
	localparam logic [KindW-1:0] KIND_GEAR = 2'd1;
	localparam logic [KindW-1:0] KIND_MODE = 2'd2;

	// mode command codes
	localparam logic [ModeInW-1:0] CMD_OFF   = 3'd0;
	localparam logic [ModeInW-1:0] CMD_ON    = 3'd1;
	localparam logic [ModeInW-1:0] CMD_SLOW  = 3'd2;
	localparam logic [ModeInW-1:0] CMD_FAST  = 3'd3;
	localparam logic [ModeInW-1:0] CMD_FLASH = 3'd4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_INVERT    = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_FLASH_DUR = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_SLOW_IVL  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_FAST_IVL  = 2'd3;

	typedef enum logic [3:0] {
		MODE_OFF  = 4'b0001,
		MODE_ON   = 4'b0010,
		MODE_SLOW = 4'b0100,
		MODE_FAST = 4'b1000
	} mode_t;

	typedef struct packed {
		logic            invert;
		logic [CntW-1:0] flash_duration;
		logic [CntW-1:0] slow_interval;
		logic [CntW-1:0] fast_interval;
		logic            flash_clr;
	} cfg_t;

	typedef struct packed {
		logic [KindW-1:0]   kind;
		logic [GearInW-1:0] gear_value;
		logic [ModeInW-1:0] mode_value;
	} item_t;

	typedef struct packed {
		logic             analog_drive;
		logic             pin_level;
		logic [DutyW-1:0] pwm_duty;
		logic             logical_on;
	} result_t;

	function automatic logic [DutyW-1:0] gear_duty(input logic [GearW-1:0] g);
		logic [DutyW-1:0] d;
		unique case (g)
			3'd0:    d = 8'd0;
			3'd1:    d = 8'd64;
			3'd2:    d = 8'd128;
			3'd3:    d = 8'd192;
			default: d = 8'd255;
		endcase
		return d;
	endfunction

	function automatic mode_t cmd_to_mode(input logic [ModeInW-1:0] c);
		mode_t m;
		unique case (c)
			CMD_ON:   m = MODE_ON;
			CMD_SLOW: m = MODE_SLOW;
			CMD_FAST: m = MODE_FAST;
			default:  m = MODE_OFF;
		endcase
		return m;
	endfunction

endpackage

[sv/ledbf_cfg_regs.sv]
// Configuration registers of the LED indicator core.
// Depends on ledbf_pkg.
`timescale 1ns / 1ps

module ledbf_cfg_regs
	import ledbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	output cfg_t               cfg
);

	logic            invert_q;
	logic [CntW-1:0] flash_dur_q;
	logic [CntW-1:0] slow_ivl_q;
	logic [CntW-1:0] fast_ivl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q    <= 1'b0;
			flash_dur_q <= FlashDurRst;
			slow_ivl_q  <= SlowIvlRst;
			fast_ivl_q  <= FastIvlRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INVERT:    invert_q    <= cfg_data[0];
				REG_FLASH_DUR: flash_dur_q <= cfg_data;
				REG_SLOW_IVL:  slow_ivl_q  <= cfg_data;
				REG_FAST_IVL:  fast_ivl_q  <= cfg_data;
			endcase
		end
	end

	assign cfg.invert         = invert_q;
	assign cfg.flash_duration = flash_dur_q;
	assign cfg.slow_interval  = slow_ivl_q;
	assign cfg.fast_interval  = fast_ivl_q;
	// a zero flash length ends a running flash
	assign cfg.flash_clr      = cfg_we && (cfg_index == REG_FLASH_DUR) && (cfg_data == '0);

endmodule

[sv/ledbf_eval.sv]
// LED state registers and the single-pass update for one request.
// Depends on ledbf_pkg; driven from the input stage of the top level.
`timescale 1ns / 1ps

module ledbf_eval
	import ledbf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output logic    has_result,
	output result_t res
);

	mode_t           base_mode_q, mode_d;
	logic [GearW-1:0] gear_q, gear_d;
	logic [CntW-1:0] blink_el_q, blink_el_d;
	logic            phase_q, phase_d;
	logic [CntW-1:0] flash_el_q, flash_el_d;
	logic            busy_q, busy_d;
	logic            flash_lvl_q, flash_lvl_d;
	logic            lit_q, lit_d;

	logic [GearW-1:0] gear_clamp;
	mode_t            req_mode;
	logic             mode_change;
	logic [CntW-1:0]  blink_inc, flash_inc, ivl;
	logic [DutyW-1:0] duty;
	logic             dig_on, analog;

	assign has_result = (item.kind == KIND_TICK);
	assign gear_clamp = (item.gear_value > GearInW'(GearMax)) ? GearMax
		: item.gear_value[GearW-1:0];

	always_comb begin
		mode_d      = base_mode_q;
		gear_d      = gear_q;
		blink_el_d  = blink_el_q;
		phase_d     = phase_q;
		flash_el_d  = flash_el_q;
		busy_d      = busy_q;
		flash_lvl_d = flash_lvl_q;
		lit_d       = lit_q;
		req_mode    = MODE_OFF;
		mode_change = 1'b0;
		blink_inc   = (blink_el_q != CntMax) ? blink_el_q + 1'b1 : CntMax;
		flash_inc   = (flash_el_q != CntMax) ? flash_el_q + 1'b1 : CntMax;
		ivl         = (base_mode_q == MODE_FAST) ? cfg.fast_interval : cfg.slow_interval;
		duty        = gear_duty(gear_q);
		dig_on      = 1'b0;
		analog      = 1'b0;

		priority if (item.kind == KIND_GEAR) begin
			gear_d      = gear_clamp;
			req_mode    = (gear_clamp != '0) ? MODE_ON : MODE_OFF;
			mode_change = 1'b1;
		end else if (item.kind == KIND_MODE) begin
			if (item.mode_value == CMD_FLASH) begin
				if (cfg.flash_duration != '0 && base_mode_q != MODE_FAST) begin
					flash_el_d  = '0;
					flash_lvl_d = ~lit_q;
					busy_d      = 1'b1;
				end
			end else if (item.mode_value <= CMD_FAST) begin
				req_mode    = cmd_to_mode(item.mode_value);
				mode_change = 1'b1;
				if (item.mode_value == CMD_FAST)
					busy_d = 1'b0;
			end
		end else if (item.kind == KIND_TICK) begin
			blink_el_d = blink_inc;
			flash_el_d = flash_inc;
			if (busy_q && base_mode_q != MODE_FAST && flash_inc < cfg.flash_duration) begin
				dig_on = flash_lvl_q;
			end else begin
				if (busy_q && base_mode_q != MODE_FAST)
					busy_d = 1'b0;
				unique case (base_mode_q)
					MODE_ON: begin
						analog = (duty != '0);
					end
					MODE_SLOW, MODE_FAST: begin
						// toggle once the interval has run out
						if (blink_inc >= ivl) begin
							phase_d    = ~phase_q;
							blink_el_d = '0;
						end
						dig_on = phase_d;
					end
					default: dig_on = 1'b0;
				endcase
			end
			lit_d = analog | dig_on;
		end else begin
			// kind three: drop
		end

		if (mode_change && req_mode != base_mode_q) begin
			mode_d     = req_mode;
			blink_el_d = '0;
			phase_d    = 1'b0;
		end

		res.analog_drive = analog;
		res.pin_level    = analog ? 1'b0 : (dig_on ^ cfg.invert);
		res.pwm_duty     = analog ? (cfg.invert ? DutyFull - duty : duty) : '0;
		res.logical_on   = analog | dig_on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_mode_q <= MODE_OFF;
			gear_q      <= '0;
			blink_el_q  <= '0;
			phase_q     <= 1'b0;
			flash_el_q  <= '0;
			busy_q      <= 1'b0;
			flash_lvl_q <= 1'b0;
			lit_q       <= 1'b0;
		end else begin
			if (fire) begin
				base_mode_q <= mode_d;
				gear_q      <= gear_d;
				blink_el_q  <= blink_el_d;
				phase_q     <= phase_d;
				flash_el_q  <= flash_el_d;
				flash_lvl_q <= flash_lvl_d;
				lit_q       <= lit_d;
			end
			if (cfg.flash_clr)
				busy_q <= 1'b0;
			else if (fire)
				busy_q <= busy_d;
		end
	end

endmodule

[sv/led_indicator_blink_flash_core.sv]
// Top level of the LED indicator core: input stage, result register, config port.
// Depends on ledbf_pkg, ledbf_cfg_regs and ledbf_eval.
//
//   channel  direction  handshake          payload
//   in       request    in_valid/in_ready  kind, gear_value, mode_value
//   out      result     out_valid/out_ready analog_drive, pin_level, pwm_duty, logical_on
//   cfg      write      cfg_we             cfg_index, cfg_data
//
// One request per cycle while the output is not stalled; a tick is registered in the
// input stage, then its result in the result register. Commands give no result.
// The input stage advances whenever the result register is empty or being taken, or when its
// request is not a tick; a stalled output holds one tick, and a second tick stops intake.
// Reset clears all mode and counter state to off, config to its defaults.
`timescale 1ns / 1ps

module led_indicator_blink_flash_core
	import ledbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [KindW-1:0]   kind,
	input  logic [GearInW-1:0] gear_value,
	input  logic [ModeInW-1:0] mode_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               analog_drive,
	output logic               pin_level,
	output logic [DutyW-1:0]   pwm_duty,
	output logic               logical_on,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    fire_s1;
	logic    has_res;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;

	ledbf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ledbf_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire_s1),
		.item       (item_s1),
		.cfg        (cfg),
		.has_result (has_res),
		.res        (res_d)
	);

	assign fire_s1  = valid_s1 && (!has_res || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (fire_s1 && has_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.kind       <= kind;
			item_s1.gear_value <= gear_value;
			item_s1.mode_value <= mode_value;
		end
		if (fire_s1 && has_res)
			res_q <= res_d;
	end

	assign out_valid    = out_valid_q;
	assign analog_drive = res_q.analog_drive;
	assign pin_level    = res_q.pin_level;
	assign pwm_duty     = res_q.pwm_duty;
	assign logical_on   = res_q.logical_on;

endmodule

[sv/ledbf_checker.sv]
// Port-level checks for the LED indicator core, bound to the top level.
// Depends on ledbf_pkg.
`timescale 1ns / 1ps

module ledbf_checker
	import ledbf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               analog_drive,
	input logic               pin_level,
	input logic [DutyW-1:0]   pwm_duty,
	input logic               logical_on
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pwm_duty) && $stable(analog_drive)
			&& $stable(pin_level) && $stable(logical_on))
		else $error("stalled result changed");

	a_analog_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && analog_drive |-> logical_on && !pin_level)
		else $error("analog result not lit or pin level set");

	a_digital_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !analog_drive |-> pwm_duty == '0)
		else $error("digital result carries a duty");

endmodule

bind led_indicator_blink_flash_core ledbf_checker u_ledbf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.analog_drive (analog_drive),
	.pin_level    (pin_level),
	.pwm_duty     (pwm_duty),
	.logical_on   (logical_on)
);

[verif/ledbf_drive_check.sv]
// Checker for the LED indicator core: predicts each tick's pin drive and compares.
// Depends on ledbf_pkg; instantiated by tb beside the core.
`timescale 1ns / 1ps

module ledbf_drive_check
	import ledbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [KindW-1:0]   kind,
	input  logic [GearInW-1:0] gear_value,
	input  logic [ModeInW-1:0] mode_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               analog_drive,
	input  logic               pin_level,
	input  logic [DutyW-1:0]   pwm_duty,
	input  logic               logical_on,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	output int unsigned        drive_faults,
	output int unsigned        drives_waiting
);

	result_t expected_drive[$];
	int unsigned drives_seen;

	// configuration copy
	logic            inv_out;
	logic [CntW-1:0] flash_len;
	logic [CntW-1:0] slow_ivl;
	logic [CntW-1:0] fast_ivl;

	// indicator state
	mode_t            base_mode;
	logic [GearW-1:0] gear_level;
	logic [CntW-1:0]  blink_count;
	logic             blink_phase;
	logic [CntW-1:0]  flash_count;
	logic             flash_busy;
	logic             flash_level;
	logic             lit_now;

	task automatic report_fault(input string what, input int unsigned want,
			input int unsigned got);
		$display("drive %0d: %s expected %0d got %0d", drives_seen, what, want, got);
		drive_faults++;
	endtask

	// a change of base mode restarts the blink clock
	task automatic set_base(input mode_t nm);
		if (base_mode != nm) begin
			base_mode   = nm;
			blink_count = '0;
			blink_phase = 1'b0;
		end
	endtask

	task automatic show_level(input logic on);
		result_t r;
		lit_now        = on;
		r.analog_drive = 1'b0;
		r.pin_level    = on ^ inv_out;
		r.pwm_duty     = '0;
		r.logical_on   = on;
		expected_drive.push_back(r);
	endtask

	task automatic advance_indicator(input logic [KindW-1:0] k, input logic [GearInW-1:0] g,
			input logic [ModeInW-1:0] m);
		logic [GearW-1:0] gc;
		logic [DutyW-1:0] duty;
		result_t          r;
		case (k)
			KIND_GEAR: begin
				gc         = (g > GearMax) ? GearMax : g[GearW-1:0];
				gear_level = gc;
				set_base((gc != '0) ? MODE_ON : MODE_OFF);
			end
			KIND_MODE: begin
				case (m)
					CMD_OFF:  set_base(MODE_OFF);
					CMD_ON:   set_base(MODE_ON);
					CMD_SLOW: set_base(MODE_SLOW);
					CMD_FAST: begin
						set_base(MODE_FAST);
						flash_busy = 1'b0;
					end
					CMD_FLASH: begin
						if (flash_len != '0 && base_mode != MODE_FAST) begin
							flash_count = '0;
							flash_level = ~lit_now;
							flash_busy  = 1'b1;
						end
					end
					default: ;
				endcase
			end
			KIND_TICK: begin
				if (blink_count != CntMax)
					blink_count = blink_count + 1'b1;
				if (flash_count != CntMax)
					flash_count = flash_count + 1'b1;
				if (flash_busy && base_mode != MODE_FAST) begin
					if (flash_count < flash_len) begin
						show_level(flash_level);
						return;
					end
					flash_busy = 1'b0;
				end
				case (base_mode)
					MODE_ON: begin
						case (gear_level)
							3'd0:    duty = 8'd0;
							3'd1:    duty = 8'd64;
							3'd2:    duty = 8'd128;
							3'd3:    duty = 8'd192;
							default: duty = 8'd255;
						endcase
						if (duty == '0) begin
							show_level(1'b0);
						end else begin
							lit_now        = 1'b1;
							r.analog_drive = 1'b1;
							r.pin_level    = 1'b0;
							r.pwm_duty     = inv_out ? DutyFull - duty : duty;
							r.logical_on   = 1'b1;
							expected_drive.push_back(r);
						end
					end
					MODE_SLOW, MODE_FAST: begin
						if (blink_count >= ((base_mode == MODE_SLOW) ? slow_ivl : fast_ivl)) begin
							blink_phase = ~blink_phase;
							blink_count = '0;
						end
						show_level(blink_phase);
					end
					default: show_level(1'b0);
				endcase
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			inv_out     = 1'b0;
			flash_len   = FlashDurRst;
			slow_ivl    = SlowIvlRst;
			fast_ivl    = FastIvlRst;
			base_mode   = MODE_OFF;
			gear_level  = '0;
			blink_count = '0;
			blink_phase = 1'b0;
			flash_count = '0;
			flash_busy  = 1'b0;
			flash_level = 1'b0;
			lit_now     = 1'b0;
			drives_seen = 0;
			expected_drive.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INVERT: inv_out = cfg_data[0];
					REG_FLASH_DUR: begin
						flash_len = cfg_data;
						// a zero duration also ends a running flash
						if (cfg_data == '0)
							flash_busy = 1'b0;
					end
					REG_SLOW_IVL: slow_ivl = cfg_data;
					REG_FAST_IVL: fast_ivl = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_drive.size() == 0) begin
					report_fault("drive with no tick pending", 0, 1);
				end else begin
					want = expected_drive.pop_front();
					if (analog_drive !== want.analog_drive)
						report_fault("analog_drive", 32'(want.analog_drive), 32'(analog_drive));
					if (pin_level !== want.pin_level)
						report_fault("pin_level", 32'(want.pin_level), 32'(pin_level));
					if (pwm_duty !== want.pwm_duty)
						report_fault("pwm_duty", 32'(want.pwm_duty), 32'(pwm_duty));
					if (logical_on !== want.logical_on)
						report_fault("logical_on", 32'(want.logical_on), 32'(logical_on));
				end
				drives_seen++;
			end
			if (in_valid && in_ready)
				advance_indicator(kind, gear_value, mode_value);
		end
		drives_waiting = expected_drive.size();
	end

endmodule

[verif/tb.sv]
// Testbench top for the LED indicator core: clock, reset, requests, config and verdict.
// Depends on ledbf_pkg, led_indicator_blink_flash_core and ledbf_drive_check.
`timescale 1ns / 1ps

module tb;
	import ledbf_pkg::*;

	// kind code the core ignores
	localparam logic [KindW-1:0] KIND_NONE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [KindW-1:0]   kind = KIND_TICK;
	logic [GearInW-1:0] gear_value = '0;
	logic [ModeInW-1:0] mode_value = CMD_OFF;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               analog_drive;
	logic               pin_level;
	logic [DutyW-1:0]   pwm_duty;
	logic               logical_on;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = REG_INVERT;
	logic [CfgW-1:0]    cfg_data = '0;

	int unsigned drive_faults;
	int unsigned drives_waiting;
	logic        calm = 1'b0;
	int unsigned stall_left = 0;

	led_indicator_blink_flash_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.gear_value  (gear_value),
		.mode_value  (mode_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.analog_drive(analog_drive),
		.pin_level   (pin_level),
		.pwm_duty    (pwm_duty),
		.logical_on  (logical_on),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	ledbf_drive_check check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.gear_value    (gear_value),
		.mode_value    (mode_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.analog_drive  (analog_drive),
		.pin_level     (pin_level),
		.pwm_duty      (pwm_duty),
		.logical_on    (logical_on),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.drive_faults  (drive_faults),
		.drives_waiting(drives_waiting)
	);

	always #6 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		if ($urandom_range(0, 99) < 75)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && arst_n && $urandom_range(0, 99) < 25) begin
			out_ready  <= 1'b0;
			stall_left <= gap_len() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_request(input logic [KindW-1:0] k, input logic [GearInW-1:0] g,
			input logic [ModeInW-1:0] m);
		int unsigned gap;
		gap = (calm || $urandom_range(0, 99) < 65) ? 0 : gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		gear_value <= g;
		mode_value <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic tick();
		send_request(KIND_TICK, GearInW'($urandom_range(0, 255)),
			ModeInW'($urandom_range(0, 7)));
	endtask

	task automatic set_gear(input logic [GearInW-1:0] g);
		send_request(KIND_GEAR, g, ModeInW'($urandom_range(0, 7)));
	endtask

	task automatic set_mode(input logic [ModeInW-1:0] m);
		send_request(KIND_MODE, GearInW'($urandom_range(0, 255)), m);
	endtask

	// hold requests until every drive is back and the input stage has drained
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (drives_waiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic write_config(input logic [CfgW-1:0] al, input logic [CfgW-1:0] fd,
			input logic [CfgW-1:0] si, input logic [CfgW-1:0] fi);
		put_reg(REG_INVERT, al);
		put_reg(REG_FLASH_DUR, fd);
		put_reg(REG_SLOW_IVL, si);
		put_reg(REG_FAST_IVL, fi);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// random request; returns 0 for requests the core simply drops
	task automatic send_random(output bit counted);
		int unsigned r;
		r       = $urandom_range(0, 99);
		counted = 1'b1;
		if (r < 62) begin
			tick();
		end else if (r < 72) begin
			set_gear(GearInW'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 5)
				: $urandom_range(0, 255)));
		end else if (r < 94) begin
			if ($urandom_range(0, 99) < 88) begin
				set_mode(ModeInW'($urandom_range(CMD_OFF, CMD_FLASH)));
			end else begin
				set_mode(ModeInW'($urandom_range(CMD_FLASH + 1, 7)));
				counted = 1'b0;
			end
		end else begin
			send_request(KIND_NONE, GearInW'($urandom_range(0, 255)),
				ModeInW'($urandom_range(0, 7)));
			counted = 1'b0;
		end
	endtask

	initial begin
		int unsigned done;
		bit          counted;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, every command but off, ignored codes, gear table
		tick();
		send_request(KIND_NONE, 8'hAA, 3'b101);
		set_mode(CMD_ON);
		tick();
		set_gear(8'hFF);
		tick();
		set_gear(8'd1);
		tick();
		set_gear(8'd2);
		tick();
		set_gear(8'd3);
		tick();
		set_gear(8'd5);
		for (int m = CMD_FLASH + 1; m < 8; m++)
			set_mode(ModeInW'(m));
		tick();
		set_mode(CMD_FLASH);
		tick();
		set_mode(CMD_FAST);
		set_mode(CMD_FLASH);
		tick();
		set_gear(8'd0);
		tick();
		set_mode(CMD_SLOW);
		tick();

		// flash cut short by a zero duration, then refused while zero
		wait_idle();
		write_config(16'd0, 16'd6, 16'd3, 16'd2);
		set_mode(CMD_SLOW);
		tick();
		set_mode(CMD_FLASH);
		tick();
		tick();
		wait_idle();
		write_config(16'd0, 16'd0, 16'd3, 16'd2);
		tick();
		tick();
		set_mode(CMD_FLASH);
		tick();
		set_mode(CMD_OFF);
		tick();

		// random phases over several register settings
		for (int phase = 0; phase < 8; phase++) begin
			wait_idle();
			case (phase)
				0: write_config(16'd0, 16'd0, 16'd0, 16'd0);
				1: write_config(16'd1, 16'd1, 16'd1, 16'd1);
				2: write_config(CfgW'($urandom_range(0, 65535)), 16'hFFFF,
					CfgW'($urandom_range(2, 6)), CfgW'($urandom_range(1, 4)));
				default: write_config(CfgW'($urandom_range(0, 65535)),
					CfgW'($urandom_range(0, 12)), CfgW'($urandom_range(0, 8)),
					CfgW'($urandom_range(0, 8)));
			endcase
			calm <= (phase == 3);
			done = 0;
			while (done < 90) begin
				send_random(counted);
				if (counted)
					done++;
				if (done == 45 && phase == 5)
					wait_idle();
			end
		end

		// longest settings: full-scale interval and flash
		wait_idle();
		write_config(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		calm <= 1'b1;
		set_mode(CMD_SLOW);
		set_mode(CMD_FLASH);
		repeat (40) tick();
		set_mode(CMD_FAST);
		repeat (3) tick();

		wait_idle();
		repeat (8) @(negedge clk);
		if (drive_faults == 0 && drives_waiting == 0)
			$display("led_indicator_blink_flash_core regression: pass");
		else
			$display("led_indicator_blink_flash_core regression: fail");
		$finish;
	end

	initial begin
		#18ms;
		$display("led_indicator_blink_flash_core regression: fail");
		$finish;
	end

endmodule

[sim.f]
sv/ledbf_pkg.sv
sv/ledbf_cfg_regs.sv
sv/ledbf_eval.sv
sv/led_indicator_blink_flash_core.sv
sv/ledbf_checker.sv
verif/ledbf_drive_check.sv
verif/tb.sv
